FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, muted during rst
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, muted during rst
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lapt_pkg.sv
// Types and constants for the looping animation phase timer.
// No dependencies; imported by the top level and the testbench.
package lapt_pkg;

  localparam int CFG_W    = 16;  // config data and 16-bit fields
  localparam int IDX_W    = 3;   // config register index
  localparam int TIME_W   = 32;  // millisecond time and counters
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int DIR_W    = 2;
  localparam int LEN_W    = CFG_W + 1;  // frames plus tail, no wrap

  // frames of pause at the end of each pass
  localparam logic [LEN_W-1:0] DELAY_FRAMES = LEN_W'(5);
  // a pass holds frames + 1 shown frames and the delay frames
  localparam logic [LEN_W-1:0] PASS_TAIL = DELAY_FRAMES + LEN_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK       = 3'd0,
    KIND_RESTART    = 3'd1,
    KIND_PLAY_KEEP  = 3'd2,
    KIND_PLAY_RESET = 3'd3,
    KIND_PAUSE      = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE     = 2'd0,
    ST_FRAME    = 2'd1,
    ST_FINISHED = 2'd2
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_DURATION   = 3'd0,
    REG_INTERVAL   = 3'd1,
    REG_LOOP_LIMIT = 3'd2,
    REG_DIRECTION  = 3'd3,
    REG_FRAME_MODE = 3'd4
  } reg_idx_t;

  localparam logic [DIR_W-1:0] DIR_FORWARD   = 2'b01;
  localparam logic [DIR_W-1:0] DIR_ALTERNATE = 2'b00;

  localparam logic [CFG_W-1:0] RST_DURATION   = 16'd1000;
  localparam logic [CFG_W-1:0] RST_INTERVAL   = 16'd20;
  localparam logic [CFG_W-1:0] RST_LOOP_LIMIT = 16'd0;
  localparam logic [DIR_W-1:0] RST_DIRECTION  = DIR_FORWARD;
  localparam logic             RST_FRAME_MODE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_FR_LD,
    S_FR_RUN,
    S_EXE_LD,
    S_EXE_RUN,
    S_LOOP_LD,
    S_LOOP_RUN,
    S_CHECK,
    S_PH_LD,
    S_PH_RUN,
    S_DONE
  } lapt_state_t;

endpackage

FILE: rtl/core/looping_animation_phase_timer_top.sv
// Looping animation phase timer: top level with sequencer and shared divider.
// Depends on lapt_pkg and assert_macros.svh.
//
//  port group  | dir | handshake           | payload
//  ------------+-----+---------------------+------------------------------------
//  input beat  | in  | in_valid / in_ready | kind, now_ms
//  result beat | out | out_valid/out_ready | status, phase, frame_in_pass,
//              |     |                     | pass_index
//  config      | in  | cfg_we (no wait)    | cfg_index, cfg_data
//
// One beat at a time. Pause, unused kinds and ignored plays go from S_IDLE
// straight to S_DONE, ticks that do not fire through S_TICK. A firing tick
// runs up to four divisions through one restoring divider, one quotient bit
// per cycle: interval, elapsed time (time mode only), pass split and phase,
// each loaded in its own _LD state and run in its _RUN state.
// rst is synchronous; it resets control, configuration and timer state, not the datapath.
// A result waits in the output register while in_ready is back up; the next
// result stalls in S_DONE until the output register is free.
module looping_animation_phase_timer_top
  import lapt_pkg::*;
#(
  parameter int PHASE_FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [IDX_W-1:0]               cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  // input beats
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [KIND_W-1:0]              kind,
  input  logic [TIME_W-1:0]              now_ms,
  // result beats
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [STATUS_W-1:0]            status,
  output logic [PHASE_FRACTION_BITS:0]   phase,
  output logic [CFG_W-1:0]               frame_in_pass,
  output logic [CFG_W-1:0]               pass_index
);

  `include "assert_macros.svh"

  localparam int F        = PHASE_FRACTION_BITS;
  localparam int PH_W     = F + 1;                 // Q1.F phase
  localparam int PH_NUM_W = F + CFG_W + 1;         // (pass << F) + frames/2
  localparam int NW       = (PH_NUM_W > TIME_W) ? PH_NUM_W : TIME_W;
  localparam int CW       = $clog2(NW + 1);
  localparam int SH_16    = NW - CFG_W;
  localparam int SH_32    = NW - TIME_W;
  localparam int SH_PH    = NW - PH_NUM_W;
  localparam logic [PH_W-1:0] PH_ONE = {1'b1, {F{1'b0}}};

  // configuration registers
  logic [CFG_W-1:0] duration_ms;
  logic [CFG_W-1:0] frame_interval_ms;
  logic [CFG_W-1:0] loop_limit;
  logic [DIR_W-1:0] play_direction;
  logic             frame_counted_mode;

  // timer state
  logic [TIME_W-1:0] last_frame_time;
  logic [TIME_W-1:0] elapsed_count;
  logic              suspended;
  logic [CFG_W-1:0]  latched_interval;

  // per-beat working registers
  lapt_state_t       state, state_next;
  logic [TIME_W-1:0] now_q;
  logic [CFG_W-1:0]  frames;
  logic [TIME_W-1:0] exe;
  logic [LEN_W-1:0]  pass;
  logic [TIME_W-1:0] loops;

  // staged result, then output register
  logic [STATUS_W-1:0] res_status;
  logic [PH_W-1:0]     res_phase;
  logic [CFG_W-1:0]    res_frame;
  logic [CFG_W-1:0]    res_pass;

  // shared restoring divider
  logic [NW-1:0]    div_num;   // numerator shifts out, quotient shifts in
  logic [LEN_W-1:0] div_rem;
  logic [LEN_W-1:0] div_den;
  logic [CW-1:0]    div_cnt;
  logic [LEN_W:0]   div_trial;
  logic             div_go;
  logic             div_done;
  logic             div_load;
  logic [NW-1:0]    div_num_in;
  logic [LEN_W-1:0] div_den_in;
  logic [CW-1:0]    div_len_in;

  // combinational helpers
  logic              in_fire;
  logic              out_free;
  logic              kind_arms;
  logic              kind_ticks;
  logic [TIME_W-1:0] diff;
  logic              tick_fire;
  logic              tick_work;
  logic [LEN_W-1:0]  pass_len;
  logic [LEN_W-1:0]  pass_v;
  logic [TIME_W-1:0] loops_v;
  logic              finish_hit;
  logic              in_delay;
  logic [PH_NUM_W-1:0] ph_num;
  logic [PH_W-1:0]   ph_clamped;
  logic              reverse;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // restart and both plays need a non-zero interval to arm the timer
  assign kind_arms  = (kind == KIND_RESTART || kind == KIND_PLAY_KEEP ||
                       kind == KIND_PLAY_RESET) && (frame_interval_ms != '0);
  assign kind_ticks = (kind == KIND_TICK) || kind_arms;

  assign diff      = now_q - last_frame_time;
  assign tick_fire = !suspended && (diff >= TIME_W'(latched_interval));
  assign tick_work = tick_fire && (latched_interval != '0) && (duration_ms != '0);

  assign div_trial = {div_rem, div_num[NW-1]} - {1'b0, div_den};
  assign div_go    = !div_trial[LEN_W];
  assign div_done  = (div_cnt == '0);

  // exe - 1 wraps to all ones when exe is zero; the pass then lands on the
  // last delay frame rather than on the wrapped remainder
  assign pass_len = {1'b0, frames} + PASS_TAIL;
  assign pass_v   = (exe == '0) ? (pass_len - LEN_W'(1)) : div_rem;
  assign loops_v  = div_num[TIME_W-1:0] +
                    TIME_W'(pass_v > LEN_W'(frames));

  assign finish_hit = (loop_limit != '0) && (loops >= TIME_W'(loop_limit));
  assign in_delay   = pass > LEN_W'(frames);

  assign ph_num     = (PH_NUM_W'(pass) << F) + PH_NUM_W'(frames[CFG_W-1:1]);
  assign ph_clamped = (div_num[PH_NUM_W-1:0] > PH_NUM_W'(PH_ONE)) ?
                      PH_ONE : div_num[PH_W-1:0];
  assign reverse    = (play_direction == DIR_FORWARD)   ? 1'b0 :
                      (play_direction == DIR_ALTERNATE) ? loops[0] : 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = kind_ticks ? S_TICK : S_DONE;
      S_TICK:     state_next = tick_work ? S_FR_LD : S_DONE;
      S_FR_LD:    state_next = S_FR_RUN;
      S_FR_RUN: begin
        if (div_done) state_next = frame_counted_mode ? S_LOOP_LD : S_EXE_LD;
      end
      S_EXE_LD:   state_next = S_EXE_RUN;
      S_EXE_RUN:  if (div_done) state_next = S_LOOP_LD;
      S_LOOP_LD:  state_next = S_LOOP_RUN;
      S_LOOP_RUN: if (div_done) state_next = S_CHECK;
      S_CHECK: begin
        if (finish_hit || in_delay || frames == '0) state_next = S_DONE;
        else state_next = S_PH_LD;
      end
      S_PH_LD:    state_next = S_PH_RUN;
      S_PH_RUN:   if (div_done) state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake and divider operand selection
  always_comb begin
    in_ready   = 1'b0;
    div_load   = 1'b0;
    div_num_in = '0;
    div_den_in = '0;
    div_len_in = '0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_FR_LD: begin
        div_load   = 1'b1;
        div_num_in = NW'(duration_ms) << SH_16;
        div_den_in = LEN_W'(latched_interval);
        div_len_in = CW'(CFG_W);
      end
      S_EXE_LD: begin
        div_load   = 1'b1;
        div_num_in = NW'(elapsed_count) << SH_32;
        div_den_in = LEN_W'(latched_interval);
        div_len_in = CW'(TIME_W);
      end
      S_LOOP_LD: begin
        div_load   = 1'b1;
        div_num_in = NW'(exe - TIME_W'(1)) << SH_32;
        div_den_in = pass_len;
        div_len_in = CW'(TIME_W);
      end
      S_PH_LD: begin
        div_load   = 1'b1;
        div_num_in = NW'(ph_num) << SH_PH;
        div_den_in = LEN_W'(frames);
        div_len_in = CW'(PH_NUM_W);
      end
      default: ;
    endcase
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      duration_ms        <= RST_DURATION;
      frame_interval_ms  <= RST_INTERVAL;
      loop_limit         <= RST_LOOP_LIMIT;
      play_direction     <= RST_DIRECTION;
      frame_counted_mode <= RST_FRAME_MODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DURATION:   duration_ms        <= cfg_data;
        REG_INTERVAL:   frame_interval_ms  <= cfg_data;
        REG_LOOP_LIMIT: loop_limit         <= cfg_data;
        REG_DIRECTION:  play_direction     <= cfg_data[DIR_W-1:0];
        REG_FRAME_MODE: frame_counted_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // divider: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (div_load) begin
      div_num <= div_num_in;
      div_den <= div_den_in;
      div_rem <= '0;
      div_cnt <= div_len_in;
    end else if (!div_done) begin
      div_num <= {div_num[NW-2:0], div_go};
      div_rem <= div_go ? div_trial[LEN_W-1:0]
                        : {div_rem[LEN_W-2:0], div_num[NW-1]};
      div_cnt <= div_cnt - CW'(1);
    end
  end

  // sequencer, timer state and results
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      last_frame_time  <= '0;
      elapsed_count    <= '0;
      suspended        <= 1'b1;
      latched_interval <= '0;
    end else begin
      state <= state_next;
      // a new result takes the slot as soon as the old one leaves
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            now_q      <= now_ms;
            res_status <= ST_NONE;
            res_phase  <= '0;
            res_frame  <= '0;
            res_pass   <= '0;
            unique case (kind) inside
              KIND_RESTART: begin
                if (kind_arms) begin
                  last_frame_time  <= now_ms;
                  elapsed_count    <= '0;
                  suspended        <= 1'b0;
                  latched_interval <= frame_interval_ms;
                end
              end
              KIND_PLAY_KEEP, KIND_PLAY_RESET: begin
                if (kind_arms) begin
                  suspended        <= 1'b0;
                  latched_interval <= frame_interval_ms;
                  if (kind == KIND_PLAY_RESET) last_frame_time <= now_ms;
                end
              end
              KIND_PAUSE: suspended <= 1'b1;
              default: ;
            endcase
          end
        end
        S_TICK: begin
          if (tick_fire) last_frame_time <= now_q;
          if (tick_work) begin
            elapsed_count <= frame_counted_mode ? (elapsed_count + TIME_W'(1))
                                                : (elapsed_count + diff);
          end
        end
        S_FR_RUN: begin
          if (div_done) begin
            frames <= div_num[CFG_W-1:0];
            if (frame_counted_mode) exe <= elapsed_count;
          end
        end
        S_EXE_RUN: if (div_done) exe <= div_num[TIME_W-1:0];
        S_LOOP_RUN: begin
          if (div_done) begin
            pass  <= pass_v;
            loops <= loops_v;
          end
        end
        S_CHECK: begin
          if (finish_hit) begin
            suspended     <= 1'b1;
            elapsed_count <= '0;
            res_status    <= ST_FINISHED;
            res_pass      <= loops[CFG_W-1:0];
          end else if (!in_delay) begin
            // zero frames per pass leaves the phase at zero
            res_status <= ST_FRAME;
            res_frame  <= pass[CFG_W-1:0];
            res_pass   <= loops[CFG_W-1:0];
          end
        end
        S_PH_RUN: begin
          if (div_done) res_phase <= reverse ? (PH_ONE - ph_clamped) : ph_clamped;
        end
        S_DONE: begin
          if (out_free) begin
            status        <= res_status;
            phase         <= res_phase;
            frame_in_pass <= res_frame;
            pass_index    <= res_pass;
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  `ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready,
               "input accepted while a beat is still in work")
  `ASSERT_IMPLIES(a_div_rem_bound,
                  state == S_FR_RUN || state == S_EXE_RUN ||
                  state == S_LOOP_RUN || state == S_PH_RUN,
                  div_rem < div_den, "divider remainder out of range")
  `ASSERT_NEXT(a_finish_suspends, state == S_CHECK && finish_hit,
               suspended && elapsed_count == '0,
               "finish did not suspend and clear the count")
  `ASSERT_IMPLIES(a_phase_bound, out_valid, phase <= PH_ONE,
                  "phase above one")
  `ASSERT_IMPLIES(a_no_frame_clean, out_valid && status == ST_NONE,
                  phase == '0 && frame_in_pass == '0 && pass_index == '0,
                  "no-frame result carries data")

endmodule

FILE: tb/sv/looping_animation_phase_timer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the looping animation phase timer top level.
// Depends on lapt_pkg and looping_animation_phase_timer_top; nothing else.
module looping_animation_phase_timer_top_tb;
  import lapt_pkg::*;

  localparam int PH_BITS = 16;
  localparam logic [63:0] PH_ONE = 64'd1 << PH_BITS;
  // frames of pause after each pass, plus the extra shown frame
  localparam logic [31:0] PASS_EXTRA = 32'd6;
  // both remaining direction codes play backwards
  localparam logic [DIR_W-1:0] DIR_REVERSE = 2'b11;
  localparam logic [DIR_W-1:0] DIR_REV_ALT = 2'b10;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] now;
  } anim_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PH_BITS:0]    phase;
    logic [CFG_W-1:0]    frame;
    logic [CFG_W-1:0]    pass;
  } frame_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_we    = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] kind      = '0;
  logic [TIME_W-1:0] now_ms    = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [PH_BITS:0]    phase;
  logic [CFG_W-1:0]    frame_in_pass;
  logic [CFG_W-1:0]    pass_index;

  looping_animation_phase_timer_top #(
    .PHASE_FRACTION_BITS(PH_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .phase        (phase),
    .frame_in_pass(frame_in_pass),
    .pass_index   (pass_index)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  anim_cmd_t  cmd_q[$];        // beats not yet offered to the block
  frame_res_t frame_exp_q[$];  // predicted results, oldest first
  int errors = 0;
  int cycle_count = 0;
  logic [TIME_W-1:0] clock_ms = '0;  // time cursor of the random sessions

  // ---------------------------------------------------------------------------
  // Timer predictor: own copy of the registers and of the timer state.
  // Registers start at their reset values, timer starts suspended.
  // ---------------------------------------------------------------------------
  logic [31:0]      dur_reg  = 32'(RST_DURATION);
  logic [31:0]      int_reg  = 32'(RST_INTERVAL);
  logic [31:0]      lim_reg  = 32'(RST_LOOP_LIMIT);
  logic [DIR_W-1:0] dir_reg  = RST_DIRECTION;
  logic             mode_reg = RST_FRAME_MODE;

  logic [31:0] last_t   = '0;  // time of the last frame
  logic [31:0] elapsed  = '0;  // frames or ms since restart, wraps
  logic        halted   = 1'b1;
  logic [31:0] live_int = '0;  // interval latched at play or restart

  // One tick: interval test, pass split, loop limit, then the phase itself.
  function automatic frame_res_t fire_tick(logic [31:0] t);
    frame_res_t  r;
    logic [31:0] gap, count, frames, span, slot, pos, laps;
    logic [63:0] ph;
    logic        flip;
    r  = '0;
    ph = '0;
    if (halted) return r;
    gap = t - last_t;
    if (gap < live_int) return r;
    last_t = t;
    if (live_int == 0 || dur_reg == 0) return r;

    elapsed = mode_reg ? elapsed + 32'd1 : elapsed + gap;
    count   = mode_reg ? elapsed : elapsed / live_int;
    frames  = dur_reg / live_int;
    span    = frames + PASS_EXTRA;
    slot    = count % span;
    pos     = (slot == 0) ? span - 32'd1 : slot - 32'd1;
    laps    = (count - 32'd1) / span;
    // the delay frames already belong to the next pass count
    if (pos > frames) laps = laps + 32'd1;

    if (lim_reg != 0 && laps >= lim_reg) begin
      halted  = 1'b1;
      elapsed = '0;
      r.status = ST_FINISHED;
      r.pass   = laps[CFG_W-1:0];
      return r;
    end
    if (pos > frames) return r;  // inside the delay tail, no output

    if (frames != 0) begin
      ph = (({32'd0, pos} << PH_BITS) + {32'd0, frames >> 1}) / {32'd0, frames};
      if (ph > PH_ONE) ph = PH_ONE;
      if (dir_reg == DIR_FORWARD) flip = 1'b0;
      else if (dir_reg == DIR_ALTERNATE) flip = laps[0];
      else flip = 1'b1;
      if (flip) ph = PH_ONE - ph;
    end
    r.status = ST_FRAME;
    r.phase  = ph[PH_BITS:0];
    r.frame  = pos[CFG_W-1:0];
    r.pass   = laps[CFG_W-1:0];
    return r;
  endfunction

  function automatic frame_res_t predict_frame(logic [KIND_W-1:0] k, logic [TIME_W-1:0] t);
    frame_res_t r;
    r = '0;
    case (k)
      KIND_TICK: r = fire_tick(t);
      KIND_RESTART: begin
        if (int_reg != 0) begin
          last_t   = t;
          elapsed  = '0;
          halted   = 1'b0;
          live_int = int_reg;
          r = fire_tick(t);
        end
      end
      KIND_PLAY_KEEP, KIND_PLAY_RESET: begin
        if (int_reg != 0) begin
          halted   = 1'b0;
          live_int = int_reg;
          if (k == KIND_PLAY_RESET) last_t = t;
          r = fire_tick(t);
        end
      end
      KIND_PAUSE: halted = 1'b1;
      default: ;  // unused kinds do nothing
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of beats with random gaps in between.
  // Prediction happens on the edge a beat is taken.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    anim_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        frame_exp_q.push_back(predict_frame(kind, now_ms));
      // a new beat may go out only once the current one is gone
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          c = cmd_q.pop_front();
          in_valid <= 1'b1;
          kind     <= c.kind;
          now_ms   <= c.now;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(0, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: out_ready toggles in runs of its own, with long ready stretches.
  // Every result beat is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  int run_left = 0;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_res_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (frame_exp_q.size() == 0) begin
          errors++;
          $display("%0t ns: result beat with nothing expected, status %0d", $time, status);
        end else begin
          e = frame_exp_q.pop_front();
          check_field("status", 32'(e.status), 32'(status));
          check_field("phase", 32'(e.phase), 32'(phase));
          check_field("frame_in_pass", 32'(e.frame), 32'(frame_in_pass));
          check_field("pass_index", 32'(e.pass), 32'(pass_index));
        end
      end
    end
    if (run_left != 0) begin
      run_left <= run_left - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      run_left  <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
      run_left  <= ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 15);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: timeout", $time);
      $display("looping_animation_phase_timer_top_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(logic [KIND_W-1:0] k, logic [TIME_W-1:0] t);
    anim_cmd_t c;
    c.kind = k;
    c.now  = t;
    cmd_q.push_back(c);
  endtask

  // wait until every beat has been taken and every result has come back
  task automatic wait_drain();
    @(posedge clk);
    while (cmd_q.size() != 0 || in_valid || frame_exp_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one write per cycle; the predictor copy follows at once (block is idle)
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_DURATION:   dur_reg  = 32'(val);
      REG_INTERVAL:   int_reg  = 32'(val);
      REG_LOOP_LIMIT: lim_reg  = 32'(val);
      REG_DIRECTION:  dir_reg  = val[DIR_W-1:0];
      REG_FRAME_MODE: mode_reg = val[0];
      default: ;
    endcase
  endtask

  // direction and mode data carry junk in the upper bits on purpose
  task automatic set_config(logic [CFG_W-1:0] dur, logic [CFG_W-1:0] intv,
                            logic [CFG_W-1:0] lim, logic [CFG_W-1:0] dir_data,
                            logic [CFG_W-1:0] mode_data);
    write_reg(REG_DURATION, dur);
    write_reg(REG_INTERVAL, intv);
    write_reg(REG_LOOP_LIMIT, lim);
    write_reg(REG_DIRECTION, dir_data);
    write_reg(REG_FRAME_MODE, mode_data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [CFG_W-1:0] intv, dur, lim;
    logic [DIR_W-1:0] dir;
    intv = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, 40));
    dur  = (intv == 0) ? 16'($urandom_range(1, 500))
                       : 16'(intv * $urandom_range(0, 8) + $urandom_range(0, intv - 1));
    lim  = ($urandom_range(0, 4) < 3) ? 16'd0 : 16'($urandom_range(1, 5));
    dir  = 2'($urandom_range(0, 3));
    set_config(dur, intv, lim, {14'($urandom), dir},
               {15'($urandom), 1'($urandom_range(0, 1))});
  endtask

  // A session: re-arm first, then mostly ticks around the frame interval,
  // with some pauses, plays, time jumps and junk kinds mixed in.
  task automatic random_session(int n);
    int made, r, step, iv;
    made = 0;
    iv = (int_reg != 0) ? int'(int_reg) : ((live_int != 0) ? int'(live_int) : 20);
    r = $urandom_range(0, 5);
    if (r < 2) clock_ms = $urandom;
    else if (r == 2) clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 200));
    push_cmd(($urandom_range(0, 1) == 0) ? KIND_RESTART : KIND_PLAY_RESET, clock_ms);
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        push_cmd(KIND_RESTART, clock_ms);
        made++;
      end else if (r < 9) begin
        push_cmd(KIND_PLAY_KEEP, clock_ms);
        made++;
      end else if (r < 12) begin
        push_cmd(KIND_PLAY_RESET, clock_ms);
        made++;
      end else if (r < 15) begin
        push_cmd(KIND_PAUSE, clock_ms);
        made++;
      end else if (r < 17) begin
        // junk kinds are ignored, they do not count
        push_cmd(3'($urandom_range(5, 7)), $urandom);
      end else if (r < 19) begin
        push_cmd(KIND_TICK, $urandom);  // tick from nowhere
        made++;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 12) step = $urandom_range(0, 2 * iv);
        else if (r < 17) step = iv;
        else if (r < 19) step = $urandom_range(0, 20 * iv);
        else step = $urandom;
        clock_ms = clock_ms + 32'(step);
        push_cmd(KIND_TICK, clock_ms);
        made++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 1000 ms pass, 20 ms frames, endless, forward, counted
    push_cmd(KIND_TICK, 32'd5);           // still suspended after reset
    push_cmd(KIND_PAUSE, 32'd0);
    push_cmd(3'd5, 32'hFFFF_FFFF);        // unused kind
    push_cmd(3'd7, 32'd0);
    push_cmd(KIND_RESTART, 32'd100);
    push_cmd(KIND_TICK, 32'd119);         // one ms short of a frame
    push_cmd(KIND_TICK, 32'd120);
    push_cmd(KIND_TICK, 32'd140);
    push_cmd(KIND_TICK, 32'hFFFF_FFFF);   // time running backwards
    push_cmd(KIND_TICK, 32'h0000_0013);   // exactly one interval across the wrap
    push_cmd(KIND_PAUSE, 32'h0000_0013);
    push_cmd(KIND_TICK, 32'h0000_0040);   // paused, nothing happens
    push_cmd(KIND_PLAY_KEEP, 32'h0000_0040);
    push_cmd(KIND_PLAY_RESET, 32'h0000_0050);
    push_cmd(3'd6, 32'h0000_0055);
    wait_drain();

    // zero interval register: play and restart ignored, old interval lives on
    set_config(16'd1000, 16'd0, 16'd0, 16'(DIR_FORWARD), 16'd1);
    push_cmd(KIND_PLAY_KEEP, 32'h0000_0060);
    push_cmd(KIND_RESTART, 32'h0000_0070);
    push_cmd(KIND_TICK, 32'h0000_0064);
    wait_drain();

    // zero duration: a due tick only moves the frame time
    set_config(16'd0, 16'd7, 16'd0, 16'(DIR_FORWARD), 16'd1);
    push_cmd(KIND_RESTART, 32'd1000);
    push_cmd(KIND_TICK, 32'd1007);
    wait_drain();

    // no frames per pass gives phase 0; a one-pass limit then finishes
    set_config(16'd3, 16'd5, 16'd1, {14'h3FFF, DIR_REV_ALT}, 16'hFFFF);
    push_cmd(KIND_RESTART, 32'd2000);
    push_cmd(KIND_TICK, 32'd2005);
    push_cmd(KIND_TICK, 32'd2010);
    wait_drain();

    // random sessions over several settings, extremes first
    for (p = 0; p < 12; p++) begin
      case (p)
        0: set_config(16'hFFFF, 16'd1, 16'hFFFF, 16'(DIR_ALTERNATE), 16'd1);
        1: set_config(16'hFFFF, 16'hFFFF, 16'd1, 16'(DIR_REVERSE), 16'd0);
        2: set_config(16'd1, 16'd1, 16'd0, 16'(DIR_ALTERNATE), 16'd1);
        3: set_config(16'd90, 16'd9, 16'd3, 16'(DIR_ALTERNATE), 16'd0);
        default: random_config();
      endcase
      if (p == 4) begin
        // hold the sender until the block has fully drained mid-session
        random_session(38);
        wait_drain();
        random_session(38);
      end else begin
        random_session(77);
      end
      wait_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_exp_q.size() != 0) begin
      errors++;
      $display("%0t ns: %0d results never arrived", $time, frame_exp_q.size());
    end
    if (errors == 0)
      $display("looping_animation_phase_timer_top_tb: PASS");
    else
      $display("looping_animation_phase_timer_top_tb: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/lapt_pkg.sv
rtl/core/looping_animation_phase_timer_top.sv
tb/sv/looping_animation_phase_timer_top_tb.sv
